/* sv/status_led_pattern_sequencer_top_defines.svh */
// Assertion macros used by the status LED sequencer checker.
`ifndef STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("status LED sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("status LED sequencer check failed");

`endif

/* sv/slps_pkg.sv */
package slps_pkg;

    localparam int LED_WORD_W   = 4;
    localparam int PAT_ID_W     = 4;
    localparam int STEP_W       = 3;
    localparam int TABLE_COLS   = 8;

    // Controller modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_CV    = 3'd2;
    localparam logic [2:0] MODE_CC    = 3'd3;
    localparam logic [2:0] MODE_CP    = 3'd4;
    localparam logic [2:0] MODE_ERROR = 3'd5;

    // Pattern codes
    localparam logic [PAT_ID_W-1:0] PAT_IDLE       = 4'd0;
    localparam logic [PAT_ID_W-1:0] PAT_WAIT       = 4'd1;
    localparam logic [PAT_ID_W-1:0] PAT_CC_CHG     = 4'd2;
    localparam logic [PAT_ID_W-1:0] PAT_CC_DIS     = 4'd3;
    localparam logic [PAT_ID_W-1:0] PAT_CV_CHG     = 4'd4;
    localparam logic [PAT_ID_W-1:0] PAT_CV_DIS     = 4'd5;
    localparam logic [PAT_ID_W-1:0] PAT_CP_CHG     = 4'd6;
    localparam logic [PAT_ID_W-1:0] PAT_CP_DIS     = 4'd7;
    localparam logic [PAT_ID_W-1:0] PAT_ERR_HS_V   = 4'd8;
    localparam logic [PAT_ID_W-1:0] PAT_ERR_LS_V   = 4'd9;
    localparam logic [PAT_ID_W-1:0] PAT_ERR_LS_I   = 4'd10;
    localparam logic [PAT_ID_W-1:0] PAT_ERR_COMM   = 4'd11;
    localparam logic [PAT_ID_W-1:0] PAT_ERR_TEMP   = 4'd12;
    localparam logic [PAT_ID_W-1:0] PAT_ERR_INT    = 4'd13;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_MATCH = 1'b1;

    typedef logic [TABLE_COLS-1:0][LED_WORD_W-1:0] pat_row_t;

    typedef struct packed {
        logic [2:0]         ctrl_mode;
        logic signed [15:0] current_sample;
        logic               internal_fault;
        logic               hs_voltage_fault;
        logic               comm_fault;
        logic               ls_voltage_fault;
        logic               ls_current_fault;
        logic               temperature_fault;
    } sample_t;

    typedef struct packed {
        logic [LED_WORD_W-1:0] led_word;
        logic                  led_write;
        logic                  status;
    } result_t;

    // Nominal step count of each pattern
    function automatic logic [3:0] pat_len(input logic [PAT_ID_W-1:0] id);
        logic [3:0] len;
        case (id)
            PAT_IDLE:   len = 4'd2;
            PAT_WAIT:   len = 4'd3;
            PAT_CC_CHG, PAT_CC_DIS, PAT_CV_CHG, PAT_CV_DIS, PAT_CP_CHG, PAT_CP_DIS:
                        len = 4'd5;
            default:    len = 4'd1;
        endcase
        return len;
    endfunction

    // LED words of each pattern, step 0 in the low nibble
    function automatic pat_row_t pat_row(input logic [PAT_ID_W-1:0] id);
        pat_row_t row;
        case (id)
            PAT_IDLE:     row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0};
            PAT_WAIT:     row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h5, 4'hA, 4'h0};
            PAT_CC_CHG:   row = {4'h0, 4'h0, 4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h0};
            PAT_CC_DIS:   row = {4'h0, 4'h0, 4'h0, 4'h8, 4'h4, 4'h2, 4'h1, 4'h0};
            PAT_CV_CHG:   row = {4'h0, 4'h0, 4'h0, 4'h7, 4'hB, 4'hD, 4'hE, 4'hF};
            PAT_CV_DIS:   row = {4'h0, 4'h0, 4'h0, 4'hE, 4'hD, 4'hB, 4'h7, 4'hF};
            PAT_CP_CHG:   row = {4'h0, 4'h0, 4'h0, 4'hF, 4'h7, 4'h3, 4'h1, 4'h0};
            PAT_CP_DIS:   row = {4'h0, 4'h0, 4'h0, 4'hF, 4'hE, 4'hC, 4'h8, 4'h0};
            PAT_ERR_HS_V: row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1};
            PAT_ERR_LS_V: row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h8};
            PAT_ERR_LS_I: row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hC};
            PAT_ERR_COMM: row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hA};
            PAT_ERR_TEMP: row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h3};
            PAT_ERR_INT:  row = {4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h9};
            default:      row = '0;
        endcase
        return row;
    endfunction

endpackage

/* sv/slps_stream_if.sv */
interface slps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/status_led_pattern_sequencer_top.sv */
// Status LED pattern sequencer.
// The sample channel carries one update tick per transaction: controller
// mode, signed low-side current and six fault flags. The result channel
// returns exactly one transaction per tick: the LED word of the current
// pattern step, a write strobe and a status bit (set when no pattern applies,
// in which case the running pattern and step are kept).
// An accepted tick's result is registered in the output register, or in the
// skid register while the receiver stalls. Throughput is one tick per cycle
// while the skid register is empty; the pattern lookup, step wrap and state
// update are combinational between the sample handshake and those registers.
// Reset clears the running pattern to idle, the step to zero and the valid
// flags of both result stages; no transaction is pending afterwards.
// When the receiver stalls, one more result is parked in a skid register, and
// sample ready drops only while that register is full, so ready never depends
// combinationally on the result side.
// MAX_STEPS caps the pattern length, LED_COUNT masks the LED word.
module status_led_pattern_sequencer_top #(
    parameter int MAX_STEPS = 5,
    parameter int LED_COUNT = 4
) (
    input logic          clk,
    input logic          rst_n,
    slps_stream_if.sink   sample,
    slps_stream_if.source result
);

    localparam logic [3:0] STEP_CAP = 4'(MAX_STEPS);
    localparam logic [slps_pkg::LED_WORD_W-1:0] LED_MASK =
        (LED_COUNT >= slps_pkg::LED_WORD_W) ? {slps_pkg::LED_WORD_W{1'b1}}
        : slps_pkg::LED_WORD_W'((1 << LED_COUNT) - 1);

    logic [slps_pkg::PAT_ID_W-1:0] pattern_id_reg, pattern_id_next;
    logic [slps_pkg::STEP_W-1:0]   step_index_reg, step_index_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          skid_valid_reg, skid_valid_next;
    slps_pkg::result_t             out_data_reg, out_data_next;
    slps_pkg::result_t             skid_data_reg, skid_data_next;

    slps_pkg::sample_t             smp;
    slps_pkg::result_t             res;
    logic                          accept;
    logic                          pick_valid;
    logic [slps_pkg::PAT_ID_W-1:0] pick_id;
    logic                          discharge;
    logic [3:0]                    nom_len;
    logic [3:0]                    eff_len;
    logic [3:0]                    step_inc;
    logic [slps_pkg::STEP_W-1:0]   step_sel;
    slps_pkg::pat_row_t            row;

    assign smp          = sample.payload;
    assign sample.ready = !skid_valid_reg;
    assign accept       = sample.valid && sample.ready;
    assign discharge    = smp.current_sample[15];

    // Pick the pattern from mode, current sign and fault priority
    always_comb
    begin
        pick_valid = 1'b1;
        pick_id    = slps_pkg::PAT_IDLE;
        case (smp.ctrl_mode)
            slps_pkg::MODE_IDLE: pick_id = slps_pkg::PAT_IDLE;
            slps_pkg::MODE_WAIT: pick_id = slps_pkg::PAT_WAIT;
            slps_pkg::MODE_CV:
                pick_id = discharge ? slps_pkg::PAT_CV_DIS : slps_pkg::PAT_CV_CHG;
            slps_pkg::MODE_CC:
                pick_id = discharge ? slps_pkg::PAT_CC_DIS : slps_pkg::PAT_CC_CHG;
            slps_pkg::MODE_CP:
                pick_id = discharge ? slps_pkg::PAT_CP_DIS : slps_pkg::PAT_CP_CHG;
            slps_pkg::MODE_ERROR:
            begin
                if (smp.internal_fault)
                    pick_id = slps_pkg::PAT_ERR_INT;
                else if (smp.hs_voltage_fault)
                    pick_id = slps_pkg::PAT_ERR_HS_V;
                else if (smp.comm_fault)
                    pick_id = slps_pkg::PAT_ERR_COMM;
                else if (smp.ls_voltage_fault)
                    pick_id = slps_pkg::PAT_ERR_LS_V;
                else if (smp.ls_current_fault)
                    pick_id = slps_pkg::PAT_ERR_LS_I;
                else if (smp.temperature_fault)
                    pick_id = slps_pkg::PAT_ERR_TEMP;
                else
                    pick_valid = 1'b0;
            end
            default: pick_valid = 1'b0;
        endcase
    end

    // Advance or restart the step and look up the LED word
    always_comb
    begin
        nom_len  = slps_pkg::pat_len(pick_id);
        eff_len  = (nom_len > STEP_CAP) ? STEP_CAP : nom_len;
        step_inc = {1'b0, step_index_reg} + 4'd1;
        if (pick_id == pattern_id_reg)
            step_sel = (step_inc >= eff_len) ? '0 : step_inc[slps_pkg::STEP_W-1:0];
        else
            step_sel = '0;
        row = slps_pkg::pat_row(pick_id);

        if (pick_valid)
        begin
            res.led_word  = row[step_sel] & LED_MASK;
            res.led_write = 1'b1;
            res.status    = slps_pkg::STATUS_OK;
        end
        else
        begin
            res.led_word  = '0;
            res.led_write = 1'b0;
            res.status    = slps_pkg::STATUS_NO_MATCH;
        end

        pattern_id_next = pattern_id_reg;
        step_index_next = step_index_reg;
        if (accept && pick_valid)
        begin
            pattern_id_next = pick_id;
            step_index_next = step_sel;
        end
    end

    // Steer results into the output register or the skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = res;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_id_reg <= slps_pkg::PAT_IDLE;
            step_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_id_reg <= pattern_id_next;
            step_index_reg <= step_index_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

endmodule

/* sv/slps_checker.sv */
`include "status_led_pattern_sequencer_top_defines.svh"

module slps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [slps_pkg::LED_WORD_W-1:0]   led_word,
    input logic                              led_write,
    input logic                              status
);

    // A stalled result transaction keeps its payload
    `SLPS_ASSERT_NEXT(a_stall_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(led_word) && $stable(led_write) && $stable(status))

    // A tick with no matching pattern drives nothing
    `SLPS_ASSERT_NOW(a_no_match_dark, clk, rst_n, result_valid && status == slps_pkg::STATUS_NO_MATCH, !led_write && led_word == '0)

    // A matched tick always strobes the LEDs
    `SLPS_ASSERT_NOW(a_match_write, clk, rst_n, result_valid && status == slps_pkg::STATUS_OK, led_write)

endmodule

bind status_led_pattern_sequencer_top slps_checker u_slps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .led_word     (result.payload.led_word),
    .led_write    (result.payload.led_write),
    .status       (result.payload.status)
);

/* test/status_led_pattern_sequencer_top_tb.sv */
module status_led_pattern_sequencer_top_tb;

    localparam int MAX_STEPS   = 5;
    localparam int LED_COUNT   = 4;
    localparam int N_TICKS     = 1450;
    localparam int MAX_GAP     = 13;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_EVERY = 240;
    localparam int SETTLE      = 8;

    // Modes that no pattern serves
    localparam logic [2:0] MODE_UNSUP_LO = 3'd6;
    localparam logic [2:0] MODE_UNSUP_HI = 3'd7;

    // Fault flag masks, ordered {internal, hs_v, comm, ls_v, ls_i, temp}
    localparam logic [5:0] FLT_NONE = 6'b000000;
    localparam logic [5:0] FLT_INT  = 6'b100000;
    localparam logic [5:0] FLT_HS_V = 6'b010000;
    localparam logic [5:0] FLT_COMM = 6'b001000;
    localparam logic [5:0] FLT_LS_V = 6'b000100;
    localparam logic [5:0] FLT_LS_I = 6'b000010;
    localparam logic [5:0] FLT_TEMP = 6'b000001;
    localparam logic [5:0] FLT_ALL  = 6'b111111;

    typedef struct {
        slps_pkg::sample_t s;
        int unsigned       gap;
        bit                drain;
    } tick_t;

    logic clk;
    logic rst_n;

    slps_stream_if #(.payload_t(slps_pkg::sample_t)) sample_ch ();
    slps_stream_if #(.payload_t(slps_pkg::result_t)) result_ch ();

    status_led_pattern_sequencer_top #(
        .MAX_STEPS(MAX_STEPS),
        .LED_COUNT(LED_COUNT)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch)
    );

    tick_t             tick_q[$];
    slps_pkg::result_t led_due_q[$];

    // Running pattern as the checker sees it
    logic [3:0] run_pattern;
    logic [2:0] run_step;

    int outstanding;
    int taken_cnt;
    int n_errors;
    int n_got;
    int n_mode_ticks;
    int n_run_ticks;
    int n_fault_ticks;
    int n_unmatched;
    int n_wraps;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Pick the pattern for one tick; return 0 when none applies
    function automatic bit choose_pattern(input slps_pkg::sample_t s,
                                          output logic [3:0] id);
        bit discharge;
        discharge = s.current_sample < 0;
        id = slps_pkg::PAT_IDLE;
        case (s.ctrl_mode)
            slps_pkg::MODE_IDLE: id = slps_pkg::PAT_IDLE;
            slps_pkg::MODE_WAIT: id = slps_pkg::PAT_WAIT;
            slps_pkg::MODE_CV:
                id = discharge ? slps_pkg::PAT_CV_DIS : slps_pkg::PAT_CV_CHG;
            slps_pkg::MODE_CC:
                id = discharge ? slps_pkg::PAT_CC_DIS : slps_pkg::PAT_CC_CHG;
            slps_pkg::MODE_CP:
                id = discharge ? slps_pkg::PAT_CP_DIS : slps_pkg::PAT_CP_CHG;
            slps_pkg::MODE_ERROR:
            begin
                if (s.internal_fault)         id = slps_pkg::PAT_ERR_INT;
                else if (s.hs_voltage_fault)  id = slps_pkg::PAT_ERR_HS_V;
                else if (s.comm_fault)        id = slps_pkg::PAT_ERR_COMM;
                else if (s.ls_voltage_fault)  id = slps_pkg::PAT_ERR_LS_V;
                else if (s.ls_current_fault)  id = slps_pkg::PAT_ERR_LS_I;
                else if (s.temperature_fault) id = slps_pkg::PAT_ERR_TEMP;
                else return 1'b0;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Step count of a pattern, capped at MAX_STEPS
    function automatic int step_count(input logic [3:0] id);
        int n;
        case (id)
            slps_pkg::PAT_IDLE: n = 2;
            slps_pkg::PAT_WAIT: n = 3;
            slps_pkg::PAT_CC_CHG, slps_pkg::PAT_CC_DIS,
            slps_pkg::PAT_CV_CHG, slps_pkg::PAT_CV_DIS,
            slps_pkg::PAT_CP_CHG, slps_pkg::PAT_CP_DIS:
                n = 5;
            default:  n = 1;
        endcase
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        return n;
    endfunction

    // LED words of a pattern, step 0 in the top nibble
    function automatic logic [19:0] step_words(input logic [3:0] id);
        case (id)
            slps_pkg::PAT_IDLE:     return {4'h0, 4'hF, 4'h0, 4'h0, 4'h0};
            slps_pkg::PAT_WAIT:     return {4'h0, 4'hA, 4'h5, 4'h0, 4'h0};
            slps_pkg::PAT_CC_CHG:   return {4'h0, 4'h8, 4'h4, 4'h2, 4'h1};
            slps_pkg::PAT_CC_DIS:   return {4'h0, 4'h1, 4'h2, 4'h4, 4'h8};
            slps_pkg::PAT_CV_CHG:   return {4'hF, 4'hE, 4'hD, 4'hB, 4'h7};
            slps_pkg::PAT_CV_DIS:   return {4'hF, 4'h7, 4'hB, 4'hD, 4'hE};
            slps_pkg::PAT_CP_CHG:   return {4'h0, 4'h1, 4'h3, 4'h7, 4'hF};
            slps_pkg::PAT_CP_DIS:   return {4'h0, 4'h8, 4'hC, 4'hE, 4'hF};
            slps_pkg::PAT_ERR_HS_V: return {4'h1, 16'h0};
            slps_pkg::PAT_ERR_LS_V: return {4'h8, 16'h0};
            slps_pkg::PAT_ERR_LS_I: return {4'hC, 16'h0};
            slps_pkg::PAT_ERR_COMM: return {4'hA, 16'h0};
            slps_pkg::PAT_ERR_TEMP: return {4'h3, 16'h0};
            slps_pkg::PAT_ERR_INT:  return {4'h9, 16'h0};
            default:                return '0;
        endcase
    endfunction

    // Advance the running pattern by one tick and return the LED result
    function automatic slps_pkg::result_t advance_pattern(input slps_pkg::sample_t s);
        logic [3:0]        id;
        logic [19:0]       words;
        logic [3:0]        mask;
        int                len;
        int                step;
        slps_pkg::result_t r;
        r = '0;
        if (!choose_pattern(s, id))
        begin
            r.status = slps_pkg::STATUS_NO_MATCH;
            n_unmatched++;
            return r;
        end
        len  = step_count(id);
        step = 0;
        if (id == run_pattern)
        begin
            step = (int'(run_step) + 1) % len;
            if (step == 0)
                n_wraps++;
        end
        if (s.ctrl_mode == slps_pkg::MODE_ERROR)
            n_fault_ticks++;
        else if (s.ctrl_mode == slps_pkg::MODE_IDLE || s.ctrl_mode == slps_pkg::MODE_WAIT)
            n_mode_ticks++;
        else
            n_run_ticks++;
        run_pattern = id;
        run_step    = 3'(step);
        words       = step_words(id);
        mask        = (LED_COUNT >= 4) ? 4'hF : 4'((1 << LED_COUNT) - 1);
        r.led_word  = words[4 * (4 - step) +: 4] & mask;
        r.led_write = 1'b1;
        r.status    = slps_pkg::STATUS_OK;
        return r;
    endfunction

    task automatic add_tick(input logic [2:0] mode, input logic signed [15:0] cur,
                            input logic [5:0] flags, input int unsigned gap, input bit drain);
        tick_t t;
        t.s.ctrl_mode         = mode;
        t.s.current_sample    = cur;
        t.s.internal_fault    = flags[5];
        t.s.hs_voltage_fault  = flags[4];
        t.s.comm_fault        = flags[3];
        t.s.ls_voltage_fault  = flags[2];
        t.s.ls_current_fault  = flags[1];
        t.s.temperature_fault = flags[0];
        t.gap   = gap;
        t.drain = drain;
        tick_q.push_back(t);
    endtask

    // Offer queued ticks, holding each until taken, then idle its gap
    always @(posedge clk)
    begin : drive
        tick_t nxt;
        int unsigned gap_left;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (tick_q.size() == 0)
                sample_ch.valid <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                sample_ch.valid <= 1'b0;
            end
            else if (tick_q[0].drain && (sample_ch.valid || outstanding != 0))
                sample_ch.valid <= 1'b0;
            else
            begin
                nxt = tick_q.pop_front();
                sample_ch.payload <= nxt.s;
                sample_ch.valid   <= 1'b1;
                gap_left = nxt.gap;
            end
        end
    end

    // Predict on each taken tick, check each result, and pace result ready
    always @(posedge clk)
    begin : watch
        slps_pkg::result_t got;
        slps_pkg::result_t want;
        int unsigned rx_wait;
        int unsigned hold_left;
        bit rx_burst;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            outstanding     <= 0;
            taken_cnt       <= 0;
            run_pattern = slps_pkg::PAT_IDLE;
            run_step    = '0;
            rx_wait     = 0;
            hold_left   = 0;
            rx_burst    = 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (led_due_q.size() == 0)
                begin
                    $error("result with nothing pending: led_word %h led_write %b status %b",
                           got.led_word, got.led_write, got.status);
                    n_errors++;
                end
                else
                begin
                    want = led_due_q.pop_front();
                    if (got.led_word !== want.led_word)
                    begin
                        $error("led_word: expected %h, got %h", want.led_word, got.led_word);
                        n_errors++;
                    end
                    if (got.led_write !== want.led_write)
                    begin
                        $error("led_write: expected %b, got %b", want.led_write, got.led_write);
                        n_errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %b, got %b", want.status, got.status);
                        n_errors++;
                    end
                end
                n_got++;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (n_got == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                if (n_got % 96 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                led_due_q.push_back(advance_pattern(sample_ch.payload));
                taken_cnt <= taken_cnt + 1;
            end
            outstanding <= led_due_q.size();
            // Hold off for the long stall first, then the per-result stall
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [2:0]         mode;
        logic signed [15:0] cur;
        logic [5:0]         flags;
        logic [5:0]         run_flags;
        bit                 neg;
        bit                 noise;
        bit                 tx_burst;
        int unsigned        run_len;
        int unsigned        gap;
        int unsigned        r;
        int                 n_total;

        rst_n             = 1'b0;
        sample_ch.valid   = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready   = 1'b0;
        n_errors      = 0;
        n_got         = 0;
        n_mode_ticks  = 0;
        n_run_ticks   = 0;
        n_fault_ticks = 0;
        n_unmatched   = 0;
        n_wraps       = 0;
        quiet_cycles  = 0;

        // Directed: idle right after reset already runs, so it advances
        add_tick(slps_pkg::MODE_IDLE, 16'sd0, FLT_NONE, 0, 1'b0);
        add_tick(slps_pkg::MODE_IDLE, 16'sd0, FLT_NONE, $urandom_range(0, MAX_GAP), 1'b0);
        add_tick(slps_pkg::MODE_IDLE, -16'sd1, FLT_ALL, 0, 1'b0);
        // Wait pattern through a full wrap
        repeat (4)
            add_tick(slps_pkg::MODE_WAIT, 16'sd100, FLT_NONE,
                     $urandom_range(0, MAX_GAP), 1'b0);
        // Charge and discharge at the current extremes and around zero
        add_tick(slps_pkg::MODE_CV, 16'sd0, FLT_NONE, 0, 1'b0);
        add_tick(slps_pkg::MODE_CV, 16'sd32767, FLT_NONE, 0, 1'b0);
        add_tick(slps_pkg::MODE_CV, -16'sd1, FLT_NONE, 1, 1'b0);
        add_tick(slps_pkg::MODE_CV, -16'sd32768, FLT_NONE, 0, 1'b0);
        add_tick(slps_pkg::MODE_CC, 16'sd1, FLT_NONE, 0, 1'b0);
        add_tick(slps_pkg::MODE_CC, -16'sd32768, FLT_NONE, 2, 1'b0);
        add_tick(slps_pkg::MODE_CP, 16'sd32767, FLT_NONE, 0, 1'b0);
        add_tick(slps_pkg::MODE_CP, -16'sd1, FLT_NONE, 0, 1'b0);
        // Fault priority, highest first
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_ALL, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_HS_V | FLT_LS_I, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, -16'sd5, FLT_COMM | FLT_TEMP, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_LS_V, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_LS_I, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_TEMP, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_TEMP, 0, 1'b0);
        // No pattern: fault mode without flags, unsupported modes
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_NONE, 0, 1'b1);
        add_tick(MODE_UNSUP_LO, -16'sd32768, FLT_ALL, 0, 1'b0);
        add_tick(MODE_UNSUP_HI, 16'sd32767, FLT_INT, 0, 1'b0);
        add_tick(slps_pkg::MODE_ERROR, 16'sd0, FLT_TEMP, $urandom_range(0, MAX_GAP), 1'b0);

        // Random: runs of one mode so patterns step and wrap, some noise runs
        tx_burst = 1'b0;
        while (tick_q.size() < N_TICKS)
        begin
            run_len  = $urandom_range(1, 12);
            noise    = ($urandom_range(0, 9) == 0);
            tx_burst = ($urandom_range(0, 3) == 0);
            neg      = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 12)      mode = slps_pkg::MODE_IDLE;
            else if (r < 22) mode = slps_pkg::MODE_WAIT;
            else if (r < 37) mode = slps_pkg::MODE_CV;
            else if (r < 52) mode = slps_pkg::MODE_CC;
            else if (r < 67) mode = slps_pkg::MODE_CP;
            else if (r < 92) mode = slps_pkg::MODE_ERROR;
            else             mode = $urandom_range(0, 1) ? MODE_UNSUP_HI : MODE_UNSUP_LO;
            case ($urandom_range(0, 3))
                0:       run_flags = FLT_NONE;
                1:       run_flags = 6'($urandom);
                default: run_flags = 6'(1 << $urandom_range(0, 5));
            endcase
            repeat (run_len)
            begin
                if ($urandom_range(0, 9) == 0)
                    neg = ~neg;
                case ($urandom_range(0, 15))
                    0:       cur = 16'sd0;
                    1:       cur = -16'sd1;
                    2:       cur = 16'sd32767;
                    3:       cur = -16'sd32768;
                    default:
                    begin
                        cur     = 16'($urandom);
                        cur[15] = neg;
                    end
                endcase
                flags = run_flags;
                if (mode != slps_pkg::MODE_ERROR || $urandom_range(0, 7) == 0)
                    flags = 6'($urandom);
                n_total = tick_q.size();
                if (n_total >= 180 && n_total < 320)
                    gap = 0;
                else
                    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (noise)
                    add_tick(3'($urandom), 16'($urandom), 6'($urandom), gap,
                             n_total % DRAIN_EVERY == 0);
                else
                    add_tick(mode, cur, flags, gap, n_total % DRAIN_EVERY == 0);
            end
        end
        n_total = tick_q.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every tick to be taken and every result to come back
        do
            @(posedge clk);
        while (taken_cnt != n_total || outstanding != 0);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d ticks: %0d idle/wait, %0d charge/discharge, %0d fault, %0d unmatched",
                 n_total, n_mode_ticks, n_run_ticks, n_fault_ticks, n_unmatched);
        $display("Saw %0d pattern wraps, one long result stall and periodic drains", n_wraps);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/slps_pkg.sv
sv/slps_stream_if.sv
sv/status_led_pattern_sequencer_top.sv
sv/slps_checker.sv
test/status_led_pattern_sequencer_top_tb.sv
